>>> rtl/core/i2cms_pkg.sv
// Types and constants shared by the I2C register sequencer files.
package i2cms_pkg;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_ADDR      = 4'd1,
      PH_RESTARTED = 4'd2,
      PH_REP_START = 4'd3,
      PH_REG       = 4'd4,
      PH_FAIL      = 4'd6,
      PH_WRITING   = 4'd7,
      PH_STOP      = 4'd8,
      PH_READING   = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_BEGIN  = 2'd1,
      MODE_STATUS = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_TARGET_ADDRESS  = 2'd0,
      CSR_REGISTER_INDEX  = 2'd1,
      CSR_READ_NOT_WRITE  = 2'd2,
      CSR_TRANSFER_LENGTH = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ACK_KEEP  = 2'd0,
      ACK_SET   = 2'd1,
      ACK_CLEAR = 2'd2
   } ack_type;

   // controller status codes
   localparam logic [7:0] ST_START       = 8'h08;
   localparam logic [7:0] ST_REP_START   = 8'h10;
   localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
   localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
   localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
   localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST    = 8'h38;
   localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
   localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
   localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
   localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

   localparam int LEN_W  = 6;
   localparam int BYTE_W = 8;

   typedef struct packed {
      logic [1:0]        mode;
      logic [BYTE_W-1:0] status_code;
      logic [BYTE_W-1:0] bus_byte;
      logic [4:0]        load_index;
      logic [BYTE_W-1:0] load_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] send_byte;
      logic              send_valid;
      logic              request_start;
      logic              request_stop;
      logic              clear_start;
      logic              clear_interrupt;
      logic [1:0]        ack_action;
      logic [BYTE_W-1:0] received_byte;
      logic [4:0]        received_index;
      logic              received_valid;
      logic [3:0]        phase;
   } rsp_type;

endpackage

>>> rtl/core/i2cms_req_if.sv
// Request channel: valid/ready handshake carrying one input beat.
interface i2cms_req_if;
   logic              valid;
   logic              ready;
   i2cms_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/i2cms_rsp_if.sv
// Response channel: valid/ready handshake carrying one result beat.
interface i2cms_rsp_if;
   logic              valid;
   logic              ready;
   i2cms_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/i2cms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module i2cms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/i2c_master_register_sequencer.sv
// I2C master register read/write sequencer driven by controller status events.
// Takes one request beat per cycle and returns exactly one response beat for it,
// registered, on the cycle after acceptance; the request side keeps accepting
// while a response waits, as long as the response register is free or being
// drained in the same cycle. Load beats fill the write buffer, a begin beat
// raises the start request, and status beats advance the phase and tell the
// controller what to do next. The write buffer is a RAM with a registered read
// port that is kept pointed at the current byte counter, so the next data byte
// is always ready when a data-ACK status arrives. The buffer has no clearing
// pass: entries never loaded read as garbage. Configuration writes take effect
// at once and must only be issued while no transfer is in flight.
module i2c_master_register_sequencer #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   i2cms_req_if.sink           req_chan,
   i2cms_rsp_if.source         rsp_chan,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data
);

   localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int LEN_W  = i2cms_pkg::LEN_W;
   localparam int BYTE_W = i2cms_pkg::BYTE_W;

   // configuration
   logic [BYTE_W-1:0] target_address_ff;
   logic [BYTE_W-1:0] register_index_ff;
   logic              read_not_write_ff;
   logic [LEN_W-1:0]  transfer_length_ff;

   // sequencer state
   i2cms_pkg::phase_type phase_ff, phase_in;
   logic [LEN_W-1:0]     count_ff, count_in, count_inc;

   // response register
   logic                 rsp_valid_ff;
   i2cms_pkg::rsp_type   rsp_data_ff;
   i2cms_pkg::rsp_type   result;

   logic accept;

   // write buffer
   logic [BUF_AW-1:0] load_slot [32];
   logic [BUF_AW-1:0] count_slot [64];
   logic              buf_we;
   logic [BUF_AW-1:0] buf_wr_addr;
   logic [BUF_AW-1:0] buf_rd_addr;
   logic [BYTE_W-1:0] buf_rd_data;
   logic [BYTE_W-1:0] buf_byte;
   logic              byp_hit_ff, byp_hit_in;
   logic [BYTE_W-1:0] byp_data_ff;

   // index folding tables, constant at elaboration
   for (genvar g = 0; g < 32; g++) begin : g_load_slot
      assign load_slot[g] = BUF_AW'(g % BUFFER_DEPTH);
   end
   for (genvar g = 0; g < 64; g++) begin : g_count_slot
      assign count_slot[g] = BUF_AW'(g % BUFFER_DEPTH);
   end

   function automatic logic [1:0] ack_pick(input logic [LEN_W-1:0] len,
                                           input logic [LEN_W-1:0] cnt);
      logic [LEN_W:0] need;
      need = {1'b0, cnt} + (LEN_W+1)'(2);
      return ({1'b0, len} >= need) ? i2cms_pkg::ACK_SET : i2cms_pkg::ACK_CLEAR;
   endfunction

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_address_ff  <= '0;
         register_index_ff  <= '0;
         read_not_write_ff  <= 1'b0;
         transfer_length_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            i2cms_pkg::CSR_TARGET_ADDRESS:  target_address_ff  <= csr_data;
            i2cms_pkg::CSR_REGISTER_INDEX:  register_index_ff  <= csr_data;
            i2cms_pkg::CSR_READ_NOT_WRITE:  read_not_write_ff  <= csr_data[0];
            i2cms_pkg::CSR_TRANSFER_LENGTH: transfer_length_ff <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cms_pkg::PH_IDLE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   assign count_inc = count_ff + LEN_W'(1);
   // a load in the same cycle as the read of that entry bypasses the RAM
   assign buf_byte  = byp_hit_ff ? byp_data_ff : buf_rd_data;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      buf_we   = 1'b0;
      result   = '0;
      if (accept) begin
         case (req_chan.data.mode)
            i2cms_pkg::MODE_LOAD: begin
               buf_we = 1'b1;
            end
            i2cms_pkg::MODE_BEGIN: begin
               phase_in             = i2cms_pkg::PH_IDLE;
               result.request_start = 1'b1;
            end
            i2cms_pkg::MODE_STATUS: begin
               case (req_chan.data.status_code)
                  i2cms_pkg::ST_START: begin
                     result.send_byte       = target_address_ff;
                     result.send_valid      = 1'b1;
                     result.clear_start     = 1'b1;
                     result.clear_interrupt = 1'b1;
                     count_in               = '0;
                     phase_in               = i2cms_pkg::PH_ADDR;
                  end
                  i2cms_pkg::ST_REP_START: begin
                     if (phase_ff == i2cms_pkg::PH_REP_START) begin
                        result.send_byte       = target_address_ff | BYTE_W'(1);
                        result.send_valid      = 1'b1;
                        result.clear_start     = 1'b1;
                        result.clear_interrupt = 1'b1;
                        phase_in               = i2cms_pkg::PH_RESTARTED;
                     end else begin
                        phase_in = i2cms_pkg::PH_FAIL;
                     end
                  end
                  i2cms_pkg::ST_ADDR_W_ACK: begin
                     if (phase_ff == i2cms_pkg::PH_ADDR) begin
                        result.send_byte       = register_index_ff;
                        result.send_valid      = 1'b1;
                        result.clear_interrupt = 1'b1;
                        phase_in               = i2cms_pkg::PH_REG;
                     end else begin
                        phase_in = i2cms_pkg::PH_FAIL;
                     end
                  end
                  i2cms_pkg::ST_DATA_W_NACK: begin
                     phase_in = i2cms_pkg::PH_FAIL;
                  end
                  i2cms_pkg::ST_DATA_W_ACK: begin
                     result.clear_interrupt = 1'b1;
                     if (read_not_write_ff) begin
                        result.request_start = 1'b1;
                        phase_in             = i2cms_pkg::PH_REP_START;
                     end else if (count_ff == transfer_length_ff) begin
                        result.request_stop = 1'b1;
                        phase_in            = i2cms_pkg::PH_STOP;
                     end else begin
                        result.send_byte  = buf_byte;
                        result.send_valid = 1'b1;
                        phase_in          = i2cms_pkg::PH_WRITING;
                        count_in          = count_inc;
                     end
                  end
                  i2cms_pkg::ST_ADDR_R_ACK: begin
                     if (phase_ff == i2cms_pkg::PH_RESTARTED) begin
                        result.ack_action      = ack_pick(transfer_length_ff, count_ff);
                        result.clear_interrupt = 1'b1;
                        phase_in               = i2cms_pkg::PH_READING;
                     end else begin
                        phase_in = i2cms_pkg::PH_FAIL;
                     end
                  end
                  i2cms_pkg::ST_DATA_R_ACK: begin
                     result.received_byte   = req_chan.data.bus_byte;
                     result.received_index  = count_ff[4:0];
                     result.received_valid  = 1'b1;
                     result.ack_action      = ack_pick(transfer_length_ff, count_inc);
                     result.clear_interrupt = 1'b1;
                     count_in               = count_inc;
                  end
                  i2cms_pkg::ST_DATA_R_NACK: begin
                     result.received_byte  = req_chan.data.bus_byte;
                     result.received_index = count_ff[4:0];
                     result.received_valid = 1'b1;
                     count_in              = count_inc;
                     if (count_inc == transfer_length_ff) begin
                        result.request_stop    = 1'b1;
                        result.clear_interrupt = 1'b1;
                        phase_in               = i2cms_pkg::PH_STOP;
                     end else begin
                        phase_in = i2cms_pkg::PH_FAIL;
                     end
                  end
                  // address NACK, arbitration lost and anything unknown
                  i2cms_pkg::ST_ADDR_W_NACK, i2cms_pkg::ST_ARB_LOST,
                  i2cms_pkg::ST_ADDR_R_NACK: begin
                     result.request_stop    = 1'b1;
                     result.clear_interrupt = 1'b1;
                     phase_in               = i2cms_pkg::PH_FAIL;
                  end
                  default: begin
                     result.request_stop    = 1'b1;
                     result.clear_interrupt = 1'b1;
                     phase_in               = i2cms_pkg::PH_FAIL;
                  end
               endcase
            end
            default: ;
         endcase
      end
      result.phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         rsp_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   // read port follows the counter value of the next cycle
   assign buf_wr_addr = load_slot[req_chan.data.load_index];
   assign buf_rd_addr = count_slot[count_in];
   assign byp_hit_in  = buf_we && (buf_wr_addr == buf_rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_hit_ff <= 1'b0;
      end else begin
         byp_hit_ff <= byp_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= req_chan.data.load_byte;
   end

   i2cms_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_write_buffer (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_wr_addr),
      .wr_data (req_chan.data.load_byte),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   // a beat never both sends and receives a byte
   a_send_rx_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.send_valid && rsp_data_ff.received_valid))
      else $error("send and receive in the same response");

   // a begin beat comes back as a start request in idle
   a_begin_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.data.mode == i2cms_pkg::MODE_BEGIN) |=>
      (rsp_valid_ff && rsp_data_ff.request_start &&
       rsp_data_ff.phase == i2cms_pkg::PH_IDLE))
      else $error("begin beat did not request start");

   // start status rewinds the byte counter
   a_start_clears_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.data.mode == i2cms_pkg::MODE_STATUS &&
       req_chan.data.status_code == i2cms_pkg::ST_START) |=> (count_ff == '0))
      else $error("byte counter not cleared by start");

   // fail phase never comes with a byte to send
   a_fail_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.phase == i2cms_pkg::PH_FAIL) |->
      !rsp_data_ff.send_valid)
      else $error("byte sent on failure");

endmodule
